>>> rtl/rqpd_pkg.sv
// Package for the ready queue policy dispatcher.
// Holds payload structs, policy codes and controller command/status types.
package rqpd_pkg;

    localparam logic [2:0] POL_FIFO = 3'd0;
    localparam logic [2:0] POL_SJF  = 3'd1;
    localparam logic [2:0] POL_SRTN = 3'd2;
    localparam logic [2:0] POL_GRAT = 3'd3;
    localparam logic [2:0] POL_PRIO = 3'd4;

    localparam logic FUNC_ENQ  = 1'b0;
    localparam logic FUNC_DISP = 1'b1;

    typedef struct packed {
        logic               func;
        logic [3:0]         task_id;
        logic [15:0]        target_time;
        logic [15:0]        served_time;
        logic signed [15:0] task_priority;
    } t_in_item;

    typedef struct packed {
        logic [3:0] granted_id;
        logic       idle;
        logic [4:0] remaining_count;
    } t_out_item;

    typedef struct packed {
        logic enq;        // write input at tail
        logic scan_start; // start scan at entry 0, which becomes the first best
        logic scan_step;  // compare fetched entry against best
        logic shift_start;// begin compaction at pick
        logic shift_step; // move entry i+1 into i
        logic finish;     // decrement count, load output
        logic idle_out;   // load idle result
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        logic scan_done;
        logic shift_done;
    } t_sts;

endpackage

>>> rtl/rqpd_datapath.sv
// Datapath: slot memory, scan comparator, compaction and output register.
// Depends on rqpd_pkg for payload and command/status types.
module rqpd_datapath #(
    parameter int MAX_TASKS = 16,
    parameter int TIME_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rqpd_pkg::t_in_item i_item,
    input  logic [2:0]         i_policy,
    input  rqpd_pkg::t_cmd     i_cmd,
    output rqpd_pkg::t_sts     o_sts,
    output rqpd_pkg::t_out_item o_result
);
    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int EW = 4 + 2 * TIME_BITS + 16;

    logic [EW-1:0] mem [MAX_TASKS];
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_pick;
    logic [EW-1:0] r_best;
    logic [EW-1:0] r_rd;
    logic          r_rd_ok;
    rqpd_pkg::t_out_item r_result;

    logic [EW-1:0] n_wr;
    assign n_wr = {i_item.task_id, TIME_BITS'(i_item.target_time),
                   TIME_BITS'(i_item.served_time), i_item.task_priority};

    logic [TIME_BITS-1:0] c_tgt, c_srv, b_tgt, b_srv;
    logic signed [15:0]   b_pri;
    assign c_srv = r_rd[16 +: TIME_BITS];
    assign c_tgt = r_rd[16+TIME_BITS +: TIME_BITS];
    assign b_pri = r_best[15:0];
    assign b_srv = r_best[16 +: TIME_BITS];
    assign b_tgt = r_best[16+TIME_BITS +: TIME_BITS];

    logic [2*TIME_BITS-1:0] r_pa, r_pb;
    logic signed [TIME_BITS:0] b_rem;
    assign b_rem = $signed({1'b0, b_tgt}) - $signed({1'b0, b_srv});

    // Scan reads entry r_idx while no fetched entry is pending; r_rd_ok marks a fetched entry.
    // Products are registered in the cycle after the read, so the compare is gated by r_mul_ok.
    logic r_mul_ok;
    logic [CW-1:0] r_rd_idx, r_mul_idx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.enq) mem[r_count[IW-1:0]] <= n_wr;
        if (i_cmd.shift_step) mem[r_idx[IW-1:0]] <= r_rd;
        r_rd <= mem[i_cmd.shift_start ? IW'(r_pick + CW'(1)) :
                    i_cmd.shift_step  ? IW'(r_idx + CW'(2)) : r_idx[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_idx    <= '0;
            r_rd_ok  <= 1'b0;
            r_mul_ok <= 1'b0;
            r_result <= '0;
        end else begin
            r_rd_ok  <= 1'b0;
            r_mul_ok <= 1'b0;
            if (i_cmd.enq) r_count <= r_count + CW'(1);
            if (i_cmd.scan_start) begin
                r_idx  <= '0;
            end
            if (i_cmd.scan_step) begin
                if (r_idx < r_count && !r_rd_ok) begin
                    r_idx   <= r_idx + CW'(1);
                    r_rd_ok <= 1'b1;
                    r_rd_idx <= r_idx;
                end
                if (r_rd_ok) begin
                    r_mul_ok  <= 1'b1;
                    r_mul_idx <= r_rd_idx;
                    r_pa <= c_srv * b_tgt;
                    r_pb <= b_srv * c_tgt;
                end
            end
            if (i_cmd.shift_start) r_idx <= r_pick;
            if (i_cmd.shift_step) r_idx <= r_idx + CW'(1);
            if (i_cmd.finish) begin
                r_count <= r_count - CW'(1);
                r_result.granted_id      <= r_best[EW-1 -: 4];
                r_result.idle            <= 1'b0;
                r_result.remaining_count <= 5'(r_count - CW'(1));
            end
            if (i_cmd.idle_out) r_result <= '{granted_id: 4'd0, idle: 1'b1,
                                               remaining_count: 5'd0};
        end
    end

    // Best tracking: products of r_rd vs r_best need both stable, so the scan
    // holds each candidate in r_cand for the product cycle.
    logic [EW-1:0] r_cand;
    logic [2*TIME_BITS-1:0] q_a, q_b;
    logic [TIME_BITS-1:0] d_tgt, d_srv;
    logic signed [15:0] d_pri;
    logic signed [TIME_BITS:0] d_rem;
    logic beats2;
    assign d_pri = r_cand[15:0];
    assign d_srv = r_cand[16 +: TIME_BITS];
    assign d_tgt = r_cand[16+TIME_BITS +: TIME_BITS];
    assign d_rem = $signed({1'b0, d_tgt}) - $signed({1'b0, d_srv});
    assign q_a = r_pa;
    assign q_b = r_pb;
    always_comb begin
        case (i_policy)
            rqpd_pkg::POL_SJF:  beats2 = d_tgt < b_tgt;
            rqpd_pkg::POL_SRTN: beats2 = d_rem < b_rem;
            rqpd_pkg::POL_GRAT: beats2 = q_a < q_b;
            rqpd_pkg::POL_PRIO: beats2 = d_pri > b_pri;
            default:            beats2 = 1'b0;
        endcase
    end

    // Scan handles one fetched entry at a time to keep best stable: the product
    // cycle and then the update cycle. A new read waits while a fetched entry is pending.
    always_ff @(posedge i_clk) begin
        if (r_rd_ok && i_cmd.scan_step) r_cand <= r_rd;
        if (r_mul_ok) begin
            if (r_mul_idx == '0 || beats2) begin
                r_best <= r_cand;
                r_pick <= r_mul_idx;
            end
        end
    end

    assign o_sts.empty      = (r_count == '0);
    assign o_sts.full       = (r_count >= CW'(MAX_TASKS));
    assign o_sts.scan_done  = (r_idx >= r_count) && !r_rd_ok && !r_mul_ok;
    assign o_sts.shift_done = (r_idx + CW'(1) >= r_count);
    assign o_result = r_result;
endmodule

>>> rtl/rqpd_ctrl.sv
// Controller state machine for the dispatcher: handshake and sequencing.
// Depends on rqpd_pkg for command and status types.
module rqpd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_func,
    output logic           o_stall,
    output logic           o_valid,
    input  logic           i_out_stall,
    input  rqpd_pkg::t_sts i_sts,
    output rqpd_pkg::t_cmd o_cmd
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_WAIT  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_ovalid, n_ovalid;
    logic       acc;

    assign o_stall = (r_state != S_IDLE) ||
                     (r_ovalid && i_out_stall && i_func == rqpd_pkg::FUNC_DISP && i_sts.empty);
    assign acc     = i_valid && !o_stall;
    assign o_valid = r_ovalid;

    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid && i_out_stall;
        o_cmd    = '0;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (i_func == rqpd_pkg::FUNC_ENQ) begin
                        o_cmd.enq = !i_sts.full;
                    end else if (i_sts.empty) begin
                        o_cmd.idle_out = 1'b1;
                        n_ovalid = 1'b1;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_done) n_state = S_WAIT;
            end
            S_WAIT: begin
                o_cmd.shift_start = 1'b1;
                n_state = S_SHIFT;
            end
            S_SHIFT: begin
                if (i_sts.shift_done) n_state = S_FIN;
                else o_cmd.shift_step = 1'b1;
            end
            S_FIN: begin
                if (!(r_ovalid && i_out_stall)) begin
                    o_cmd.finish = 1'b1;
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall)
        else $error("input accepted while busy");
    a_fin_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |=> o_valid)
        else $error("dispatch result not presented");
    a_scan_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.scan_start |=> (r_state == S_SCAN))
        else $error("scan did not start");
endmodule

>>> rtl/ready_queue_policy_dispatcher_core.sv
// Ready queue policy dispatcher top level, built from rqpd_ctrl and rqpd_datapath over rqpd_pkg.
// Enqueues may follow back to back; an empty dispatch answers in the next cycle.
// A dispatch over the queued tasks scans every slot, closes up the slots behind the picked one,
// and then presents the result once any earlier result has been taken.
// A waiting result holds off only a following dispatch to an empty queue; one dispatch is in flight at a time.
// Synchronous active-low reset empties the queue and sets the policy to fifo.
module ready_queue_policy_dispatcher_core #(
    parameter int MAX_TASKS = 16,
    parameter int TIME_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  rqpd_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output rqpd_pkg::t_out_item o_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_data
);
    logic [2:0]     r_policy;
    rqpd_pkg::t_cmd cmd;
    rqpd_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_policy <= rqpd_pkg::POL_FIFO;
        else if (i_cfg_valid) r_policy <= i_cfg_data;
    end

    rqpd_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_func(i_data.func),
        .o_stall(o_stall), .o_valid(o_valid), .i_out_stall(i_stall),
        .i_sts(sts), .o_cmd(cmd)
    );

    rqpd_datapath #(.MAX_TASKS(MAX_TASKS), .TIME_BITS(TIME_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(i_data), .i_policy(r_policy),
        .i_cmd(cmd), .o_sts(sts), .o_result(o_data)
    );
endmodule
